// ----- design/first_fit_heap_allocator_unit_assert.svh -----
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define FFH_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define FFH_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FFH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- design/ffha_pkg.sv -----
package ffha_pkg;

    localparam int unsigned FreeEntriesDef  = 64;
    localparam int unsigned BlockEntriesDef = 256;
    localparam logic [32:0] MinAlign        = 33'd16;
    localparam logic [32:0] AddrTop         = 33'h0_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    localparam logic CfgHeapBase  = 1'b0;
    localparam logic CfgHeapBytes = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] req_size;
        logic [31:0] req_align;
        logic [31:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [31:0] result_addr;
        logic [1:0]  status;
        logic [32:0] used_bytes;
    } t_rsp;

endpackage

// ----- design/first_fit_heap_allocator_unit.sv -----
// Channel    | Direction | Signals                          | Handshake
// -----------+-----------+----------------------------------+---------------------------
// request    | in        | i_req (t_req)                    | i_start && !o_busy
// result     | out       | o_rsp (t_rsp)                    | o_done, one cycle
// config     | in        | i_cfg_index, i_cfg_data          | i_cfg_valid && o_cfg_ready
//
// Sequencing: query and unknown opcodes go straight to the result. Allocate scans
// the block table for a free slot and then the whole free-range table. Free scans
// the block table for the address, the free-range table for follower and
// predecessor, and the valid bits for an empty slot. Each table read step issues
// the index, then compares the registered data.
// Reset clears all control state and the valid bits; table contents are
// undefined until written. The receiver cannot stall: o_done is a single pulse.
module first_fit_heap_allocator_unit #(
    parameter int unsigned FREE_ENTRIES  = ffha_pkg::FreeEntriesDef,
    parameter int unsigned BLOCK_ENTRIES = ffha_pkg::BlockEntriesDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ffha_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_done,
    output ffha_pkg::t_rsp o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import ffha_pkg::*;

    localparam int unsigned FW = $clog2(FREE_ENTRIES);
    localparam int unsigned BW = $clog2(BLOCK_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BSCAN,    // block table walk (empty slot or address match)
        S_FSCAN,    // alloc: first fit over free ranges
        S_ACOMMIT,
        S_NEXT,     // free: find range starting at block end
        S_PREV,     // free: find range ending at block start
        S_EMPTY,    // free: find empty free slot
        S_FCOMMIT,
        S_DONE
    } t_state;

    // Table memories, one read port each, registered read data.
    logic [31:0] r_fs_mem [FREE_ENTRIES];
    logic [31:0] r_fl_mem [FREE_ENTRIES];
    logic [31:0] r_bs_mem [BLOCK_ENTRIES];
    logic [31:0] r_bl_mem [BLOCK_ENTRIES];
    logic [FREE_ENTRIES-1:0]  r_fvalid;
    logic [BLOCK_ENTRIES-1:0] r_bvalid;

    t_state      r_state;
    logic [31:0] r_base, r_bytes, r_cursor;
    logic [32:0] r_live;
    logic [1:0]  r_op;
    logic [32:0] r_size, r_amask;     // size, align - 1
    logic [31:0] r_faddr;
    logic        r_rdv;               // read data of previous index is valid
    logic [BW-1:0] r_bslot;
    logic        r_bfound;
    logic [FW-1:0] r_best;
    logic        r_bestv;
    logic [31:0] r_best_s, r_best_l;
    logic [32:0] r_best_p;
    logic [32:0] r_start, r_len;
    logic [31:0] r_fs_rd, r_fl_rd, r_bs_rd, r_bl_rd;
    logic [FW-1:0] r_frd_idx;
    logic [BW-1:0] r_brd_idx;
    logic        r_done;
    t_rsp        r_rsp;

    // Memory write port request
    logic          fw_en, bw_en;
    logic [FW-1:0] fw_idx;
    logic [BW-1:0] bw_idx;
    logic [31:0]   fw_s, fw_l, bw_s, bw_l;

    // Compare unit: aligned position and fit test of the entry just read.
    logic [32:0] pos_c, end_c;
    logic        fit_c;
    always_comb begin
        pos_c = ({1'b0, r_fs_rd} + r_amask) & ~r_amask;
        end_c = (pos_c - {1'b0, r_fs_rd}) + r_size;
        fit_c = (pos_c >= {1'b0, r_fs_rd}) && (end_c <= {1'b0, r_fl_rd});
    end

    // Bump path; the end test is one bit wider since the aligned position
    // can reach past 2^32.
    logic [32:0] bump_pos, limit_c, rest_c;
    logic        bump_fail;
    always_comb begin
        bump_pos = ({1'b0, r_cursor} + r_amask) & ~r_amask;
        limit_c  = {1'b0, r_base} + {1'b0, r_bytes};
        if (limit_c > AddrTop) begin
            limit_c = AddrTop;
        end
        bump_fail = (bump_pos < {1'b0, r_cursor})
                    || (({1'b0, bump_pos} + {1'b0, r_size}) > {1'b0, limit_c});
        rest_c = {1'b0, r_best_l} - (r_best_p - {1'b0, r_best_s}) - r_size;
    end

    logic [32:0] size_in, amask_in;
    always_comb begin
        size_in  = (i_req.req_size == 32'd0) ? 33'd1 : {1'b0, i_req.req_size};
        amask_in = ({1'b0, i_req.req_align} < MinAlign) ? MinAlign - 33'd1
                                                         : {1'b0, i_req.req_align} - 33'd1;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        r_fs_rd <= r_fs_mem[r_frd_idx];
        r_fl_rd <= r_fl_mem[r_frd_idx];
        r_bs_rd <= r_bs_mem[r_brd_idx];
        r_bl_rd <= r_bl_mem[r_brd_idx];
        if (fw_en) begin
            r_fs_mem[fw_idx] <= fw_s;
            r_fl_mem[fw_idx] <= fw_l;
        end
        if (bw_en) begin
            r_bs_mem[bw_idx] <= bw_s;
            r_bl_mem[bw_idx] <= bw_l;
        end
    end

    // Index of the entry whose read data sits in the *_rd registers
    logic [FW-1:0] fcur;
    logic [BW-1:0] bcur;
    logic          flast;
    logic          blast;
    always_comb begin
        fcur  = r_frd_idx;
        bcur  = r_brd_idx;
        flast = ({1'b0, fcur} == (FW+1)'(FREE_ENTRIES - 1));
        blast = ({1'b0, bcur} == (BW+1)'(BLOCK_ENTRIES - 1));
    end

    always_comb begin
        fw_en  = 1'b0;
        fw_idx = r_best;
        fw_s   = r_start[31:0];
        fw_l   = r_len[31:0];
        bw_en  = 1'b0;
        bw_idx = r_bslot;
        bw_s   = r_start[31:0];
        bw_l   = r_size[31:0];
        if (r_state == S_ACOMMIT) begin
            bw_en = r_bestv || !bump_fail;
            bw_s  = r_bestv ? r_best_p[31:0] : bump_pos[31:0];
            fw_en = r_bestv && (rest_c != 33'd0);
            fw_s  = 32'(r_best_p + r_size);
            fw_l  = rest_c[31:0];
        end else if (r_state == S_FCOMMIT) begin
            fw_en = r_bestv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_bytes   <= '0;
            r_cursor  <= '0;
            r_live    <= '0;
            r_fvalid  <= '0;
            r_bvalid  <= '0;
            r_done    <= 1'b0;
            r_frd_idx <= '0;
            r_brd_idx <= '0;
            r_rdv     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == CfgHeapBase) begin
                            if (r_base == 32'd0 && i_cfg_data != 32'd0) begin
                                r_base   <= i_cfg_data;
                                r_cursor <= i_cfg_data;
                                r_fvalid <= '0;
                                r_bvalid <= '0;
                                r_live   <= '0;
                            end
                        end else begin
                            r_bytes <= i_cfg_data;
                        end
                    end
                    if (i_start) begin
                        r_op      <= i_req.operation;
                        r_size    <= size_in;
                        r_amask   <= amask_in;
                        r_faddr   <= i_req.free_addr;
                        r_bfound  <= 1'b0;
                        r_bestv   <= 1'b0;
                        r_rdv     <= 1'b0;
                        r_brd_idx <= '0;
                        r_frd_idx <= '0;
                        r_rsp     <= '0;
                        unique case (t_op'(i_req.operation))
                            OP_ALLOC: begin
                                if (r_base == 32'd0) begin
                                    r_rsp.status <= ST_NOSPACE;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_BSCAN;
                                end
                            end
                            OP_FREE: begin
                                if (i_req.free_addr == 32'd0) begin
                                    r_rsp.status <= ST_UNKNOWN;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_BSCAN;
                                end
                            end
                            OP_QUERY: begin
                                r_rsp.used_bytes <= {1'b0, r_cursor} - {1'b0, r_base}
                                                    + r_live;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_BSCAN: begin
                    // r_rdv marks that r_bs_rd/r_bl_rd hold entry bcur
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else if (r_op == OP_ALLOC) begin
                        if (!r_bvalid[bcur]) begin
                            r_bslot   <= bcur;
                            r_rdv     <= 1'b0;
                            r_frd_idx <= '0;
                            r_state   <= S_FSCAN;
                        end else if (blast) begin
                            r_rsp.status <= ST_FULL;
                            r_state      <= S_DONE;
                        end else begin
                            r_brd_idx <= bcur + BW'(1);
                            r_rdv     <= 1'b0;
                        end
                    end else begin
                        if (r_bvalid[bcur] && r_bs_rd == r_faddr) begin
                            r_bvalid[bcur] <= 1'b0;
                            r_live   <= r_live - {1'b0, r_bl_rd};
                            r_start  <= {1'b0, r_faddr};
                            r_len    <= {1'b0, r_bl_rd};
                            r_rdv    <= 1'b0;
                            r_frd_idx <= '0;
                            r_state  <= S_NEXT;
                        end else if (blast) begin
                            r_rsp.status <= ST_UNKNOWN;
                            r_state      <= S_DONE;
                        end else begin
                            r_brd_idx <= bcur + BW'(1);
                            r_rdv     <= 1'b0;
                        end
                    end
                end
                S_FSCAN: begin
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else begin
                        if (r_fvalid[fcur] && fit_c
                            && (!r_bestv || r_fs_rd < r_best_s)) begin
                            r_bestv  <= 1'b1;
                            r_best   <= fcur;
                            r_best_s <= r_fs_rd;
                            r_best_l <= r_fl_rd;
                            r_best_p <= pos_c;
                        end
                        if (flast) begin
                            r_state <= S_ACOMMIT;
                        end else begin
                            r_frd_idx <= fcur + FW'(1);
                            r_rdv     <= 1'b0;
                        end
                    end
                end
                S_ACOMMIT: begin
                    if (r_bestv) begin
                        r_fvalid[r_best] <= (rest_c != 33'd0);
                        r_bvalid[r_bslot] <= 1'b1;
                        r_live <= r_live + r_size;
                        r_rsp.result_addr <= r_best_p[31:0];
                        r_rsp.status      <= ST_OK;
                    end else if (bump_fail) begin
                        r_rsp.status <= ST_NOSPACE;
                    end else begin
                        r_cursor <= 32'(bump_pos + r_size);
                        r_bvalid[r_bslot] <= 1'b1;
                        r_live <= r_live + r_size;
                        r_rsp.result_addr <= bump_pos[31:0];
                        r_rsp.status      <= ST_OK;
                    end
                    r_state <= S_DONE;
                end
                S_NEXT, S_PREV: begin
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else begin
                        if (r_fvalid[fcur] && (r_state == S_NEXT
                                ? ({1'b0, r_fs_rd} == r_start + r_len)
                                : ({1'b0, r_fs_rd} + {1'b0, r_fl_rd} == r_start))) begin
                            r_fvalid[fcur] <= 1'b0;
                            r_len <= r_len + {1'b0, r_fl_rd};
                            if (r_state == S_PREV) begin
                                r_start <= {1'b0, r_fs_rd};
                            end
                            r_frd_idx <= '0;
                            r_rdv     <= 1'b0;
                            r_state   <= (r_state == S_NEXT) ? S_PREV : S_EMPTY;
                        end else if (flast) begin
                            r_frd_idx <= '0;
                            r_rdv     <= 1'b0;
                            r_state   <= (r_state == S_NEXT) ? S_PREV : S_EMPTY;
                        end else begin
                            r_frd_idx <= fcur + FW'(1);
                            r_rdv     <= 1'b0;
                        end
                    end
                end
                S_EMPTY: begin
                    // valid bits only, no memory read needed
                    if (!r_fvalid[fcur]) begin
                        r_best  <= fcur;
                        r_bestv <= 1'b1;
                        r_state <= S_FCOMMIT;
                    end else if (flast) begin
                        r_state <= S_FCOMMIT;
                    end else begin
                        r_frd_idx <= fcur + FW'(1);
                    end
                end
                S_FCOMMIT: begin
                    if (r_bestv) begin
                        r_fvalid[r_best] <= 1'b1;
                        r_rsp.status     <= ST_OK;
                    end else begin
                        r_rsp.status <= ST_FULL;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "first_fit_heap_allocator_unit_assert.svh"

    `FFH_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "done held two cycles")
    `FFH_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, r_state == S_IDLE || r_state == S_BSCAN || r_state == S_DONE || r_state == S_IDLE, "done not followed by idle pass")
    `FFH_ASSERT_IMPL(a_ok_addr, i_clk, i_rst_n, (o_done && r_op == OP_ALLOC && o_rsp.status == ST_OK) |-> (o_rsp.result_addr != 32'd0), "alloc ok with zero address")

endmodule

// ----- tb/sv/first_fit_heap_allocator_unit_checker.sv -----
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  ffha_pkg::t_req i_req,
    input  logic           i_done,
    input  ffha_pkg::t_rsp i_rsp,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output int             o_checked,
    output int             o_pending,
    output int             o_errors
);
    import ffha_pkg::*;

    localparam int NFREE = FreeEntriesDef;
    localparam int NBLK  = BlockEntriesDef;
    localparam logic [63:0] USED_MASK = 64'h1_FFFF_FFFF;

    // shadow allocator state
    logic [31:0] base_q, bytes_q, cursor_q;
    logic [31:0] fr_start [NFREE];
    logic [31:0] fr_len   [NFREE];
    logic        fr_vld   [NFREE];
    logic [31:0] bl_start [NBLK];
    logic [31:0] bl_len   [NBLK];
    logic        bl_vld   [NBLK];
    logic [63:0] live_sum;

    t_rsp expected_rsp_q [$];

    function automatic logic [63:0] round_up(logic [63:0] x, logic [63:0] a);
        return (x + a - 64'd1) & ~(a - 64'd1);
    endfunction

    task automatic heap_alloc(input logic [63:0] size_in, input logic [63:0] align_in,
                              output logic [31:0] addr, output t_status st);
        logic [63:0] size, align, best_pos, s, l, p, rest, lim, pos;
        int slot, best;
        size = (size_in == 0) ? 64'd1 : size_in;
        align = (align_in < 64'd16) ? 64'd16 : align_in;
        addr = '0;
        best = -1;
        best_pos = 0;
        slot = -1;
        if (base_q == 0) begin
            st = ST_NOSPACE;
            return;
        end
        for (int i = 0; i < NBLK; i++) begin
            if (!bl_vld[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
            st = ST_FULL;
            return;
        end
        for (int i = 0; i < NFREE; i++) begin
            if (fr_vld[i]) begin
                s = fr_start[i];
                l = fr_len[i];
                p = round_up(s, align);
                if (!(p < s || (p - s) + size > l)) begin
                    if (best < 0 || s < {32'd0, fr_start[best]}) begin
                        best = i;
                        best_pos = p;
                    end
                end
            end
        end
        if (best >= 0) begin
            s = fr_start[best];
            rest = {32'd0, fr_len[best]} - (best_pos - s) - size;
            fr_vld[best] = 1'b0;
            if (rest > 0) begin
                fr_vld[best] = 1'b1;
                fr_start[best] = 32'(best_pos + size);
                fr_len[best] = 32'(rest);
            end
            pos = best_pos;
        end else begin
            lim = {32'd0, base_q} + {32'd0, bytes_q};
            if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
            pos = round_up({32'd0, cursor_q}, align);
            if (pos < {32'd0, cursor_q} || pos + size > lim) begin
                st = ST_NOSPACE;
                return;
            end
            cursor_q = 32'(pos + size);
        end
        bl_vld[slot] = 1'b1;
        bl_start[slot] = 32'(pos);
        bl_len[slot] = 32'(size);
        live_sum = (live_sum + size) & USED_MASK;
        addr = 32'(pos);
        st = ST_OK;
    endtask

    function automatic t_status heap_free(logic [31:0] faddr);
        int hit, slot;
        logic [63:0] start, len;
        hit = -1;
        slot = -1;
        if (faddr == 0) return ST_UNKNOWN;
        for (int i = 0; i < NBLK; i++) begin
            if (hit < 0 && bl_vld[i] && bl_start[i] == faddr) hit = i;
        end
        if (hit < 0) return ST_UNKNOWN;
        start = faddr;
        len = bl_len[hit];
        bl_vld[hit] = 1'b0;
        live_sum = (live_sum - len) & USED_MASK;
        // follower first, then predecessor
        for (int i = 0; i < NFREE; i++) begin
            if (fr_vld[i] && {32'd0, fr_start[i]} == start + len) begin
                len += fr_len[i];
                fr_vld[i] = 1'b0;
                break;
            end
        end
        for (int i = 0; i < NFREE; i++) begin
            if (fr_vld[i] && {32'd0, fr_start[i]} + {32'd0, fr_len[i]} == start) begin
                start = fr_start[i];
                len += fr_len[i];
                fr_vld[i] = 1'b0;
                break;
            end
        end
        for (int i = 0; i < NFREE; i++) begin
            if (!fr_vld[i] && slot < 0) slot = i;
        end
        if (slot < 0) return ST_FULL;
        fr_vld[slot] = 1'b1;
        fr_start[slot] = 32'(start);
        fr_len[slot] = 32'(len);
        return ST_OK;
    endfunction

    task automatic predict_result(input t_req r);
        t_rsp e;
        logic [31:0] a;
        t_status st;
        e = '0;
        case (t_op'(r.operation))
            OP_ALLOC: begin
                heap_alloc({32'd0, r.req_size}, {32'd0, r.req_align}, a, st);
                e.result_addr = a;
                e.status = st;
            end
            OP_FREE:  e.status = heap_free(r.free_addr);
            OP_QUERY: e.used_bytes = 33'(({32'd0, cursor_q} - {32'd0, base_q} + live_sum)
                                         & USED_MASK);
            default: ;
        endcase
        expected_rsp_q.push_back(e);
    endtask

    assign o_pending = expected_rsp_q.size();

    always @(posedge i_clk) begin
        t_rsp e;
        int nerr;
        nerr = 0;
        if (!i_rst_n) begin
            base_q = '0;
            bytes_q = '0;
            cursor_q = '0;
            live_sum = '0;
            for (int i = 0; i < NFREE; i++) fr_vld[i] = 1'b0;
            for (int i = 0; i < NBLK; i++) bl_vld[i] = 1'b0;
            o_checked <= 0;
            o_errors <= 0;
        end else begin
            if (i_done) begin
                o_checked <= o_checked + 1;
                if (expected_rsp_q.size() == 0) begin
                    $error("result with no request outstanding");
                    nerr++;
                end else begin
                    e = expected_rsp_q.pop_front();
                    if (i_rsp.result_addr !== e.result_addr) begin
                        $error("result_addr expected %h actual %h", e.result_addr,
                               i_rsp.result_addr);
                        nerr++;
                    end
                    if (i_rsp.status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, i_rsp.status);
                        nerr++;
                    end
                    if (i_rsp.used_bytes !== e.used_bytes) begin
                        $error("used_bytes expected %h actual %h", e.used_bytes,
                               i_rsp.used_bytes);
                        nerr++;
                    end
                end
                if (nerr != 0) o_errors <= o_errors + nerr;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgHeapBase) begin
                    if (base_q == 0 && i_cfg_data != 0) begin
                        base_q = i_cfg_data;
                        cursor_q = i_cfg_data;
                        live_sum = '0;
                        for (int i = 0; i < NFREE; i++) fr_vld[i] = 1'b0;
                        for (int i = 0; i < NBLK; i++) bl_vld[i] = 1'b0;
                    end
                end else begin
                    bytes_q = i_cfg_data;
                end
            end
            if (i_start && !i_busy) predict_result(i_req);
        end
    end
endmodule

// ----- tb/sv/first_fit_heap_allocator_unit_tb.sv -----
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_tb;
    import ffha_pkg::*;

    // worst request is a full walk of the block and free-range tables; allow plenty
    localparam int CYCLE_LIMIT = 6000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    t_req        i_req;
    logic        o_busy;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    int checked, pending, errors;
    int issued;
    int idle_pct;
    int cycles;
    logic [31:0] live_addr_pool [$];

    first_fit_heap_allocator_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req      (i_req),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    first_fit_heap_allocator_unit_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_busy     (o_busy),
        .i_req      (i_req),
        .i_done     (o_done),
        .i_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_checked  (checked),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // harvest granted addresses so frees mostly hit live blocks
    always @(posedge i_clk) begin
        if (i_rst_n && o_done && o_rsp.status == ST_OK && o_rsp.result_addr != 0)
            live_addr_pool.push_back(o_rsp.result_addr);
    end

    // One request: optional idle gap, then hold start until accepted.
    // Start is left high after acceptance so back-to-back requests never
    // drop it within a step.
    task automatic send_request(input t_req r);
        int gap;
        gap = 0;
        if (idle_pct > 0) begin
            while ($urandom_range(99) < idle_pct && gap < 20) gap++;
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_busy);
        issued++;
    endtask

    // wait until every request has its result back, then a short pause
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (checked < issued) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req make_alloc(logic [31:0] size, logic [31:0] align);
        t_req r;
        r = '0;
        r.operation = OP_ALLOC;
        r.req_size = size;
        r.req_align = align;
        r.free_addr = $urandom;
        return r;
    endfunction

    function automatic t_req make_op(t_op op, logic [31:0] faddr);
        t_req r;
        r.operation = op;
        r.req_size = $urandom;
        r.req_align = $urandom;
        r.free_addr = faddr;
        return r;
    endfunction

    // pick a live address, usually removing it (sometimes kept for a double free)
    function automatic logic [31:0] pick_live();
        int k;
        logic [31:0] a;
        if (live_addr_pool.size() == 0) return $urandom;
        k = $urandom_range(live_addr_pool.size() - 1);
        a = live_addr_pool[k];
        if ($urandom_range(9) != 0) live_addr_pool.delete(k);
        return a;
    endfunction

    function automatic t_req random_request();
        int sel;
        logic [31:0] size, align;
        sel = $urandom_range(99);
        if (sel < 55) begin
            case ($urandom_range(9))
                0: size = 0;
                1: size = $urandom;
                2: size = 32'hFFFF_FFFF;
                3: size = $urandom_range(4096, 1);
                default: size = $urandom_range(256, 1);
            endcase
            case ($urandom_range(9))
                0: align = 0;
                1: align = $urandom;                  // mostly not a power of two
                2: align = 32'h8000_0000;
                default: align = 32'd1 << $urandom_range(12);
            endcase
            return make_alloc(size, align);
        end else if (sel < 88) begin
            return make_op(OP_FREE, pick_live());
        end else if (sel < 92) begin
            return make_op(OP_FREE, ($urandom_range(1) != 0) ? 32'd0 : $urandom);
        end else if (sel < 98) begin
            return make_op(OP_QUERY, $urandom);
        end
        return make_op(OP_NONE, $urandom);
    endfunction

    initial begin
        logic [31:0] fill_addrs [$];
        issued = 0;
        idle_pct = 0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CfgHeapBase;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // uninitialized heap: base write of zero leaves it so
        write_reg(CfgHeapBase, 32'd0);
        write_reg(CfgHeapBytes, 32'd0);
        send_request(make_alloc(32'd0, 32'd0));
        send_request(make_op(OP_FREE, 32'd0));
        send_request(make_op(OP_QUERY, $urandom));
        send_request(make_op(OP_NONE, $urandom));

        // initialize; zero window length makes bump fail
        write_reg(CfgHeapBase, 32'h0001_0000);
        send_request(make_alloc(32'd1, 32'd16));
        write_reg(CfgHeapBase, 32'hFFFF_FFFF);   // ignored once initialized
        write_reg(CfgHeapBytes, 32'h0010_0000);

        // directed: extremes, odd alignment, coalescing, unknown free
        send_request(make_alloc(32'd0, 32'd0));
        send_request(make_alloc(32'd100, 32'd1));
        send_request(make_alloc(32'd64, 32'd256));
        send_request(make_alloc(32'd48, 32'd24));          // odd alignment
        send_request(make_alloc(32'hFFFF_FFFF, 32'd16));  // no space
        send_request(make_alloc(32'd16, 32'h8000_0000));  // past window
        send_request(make_alloc(32'd32, 32'hFFFF_FFFF));
        send_request(make_op(OP_QUERY, 32'd0));
        drain();
        send_request(make_op(OP_FREE, 32'h0001_0010));
        send_request(make_op(OP_FREE, 32'h0001_0000));    // freed as a range of its own
        send_request(make_op(OP_FREE, 32'h0001_0000));    // now unknown
        send_request(make_op(OP_FREE, 32'hFFFF_FFFF));
        send_request(make_alloc(32'd8, 32'd16));           // reuses free range
        send_request(make_op(OP_QUERY, 32'd0));

        // fill the block table, then free alternate blocks to fill the range table
        drain();
        live_addr_pool.delete();
        for (int i = 0; i < 270; i++) send_request(make_alloc(32'd16, 32'd16));
        drain();
        fill_addrs = live_addr_pool;
        live_addr_pool.delete();
        for (int i = 0; i < fill_addrs.size(); i += 2)
            send_request(make_op(OP_FREE, fill_addrs[i]));
        for (int i = 1; i < fill_addrs.size(); i += 2)
            send_request(make_op(OP_FREE, fill_addrs[i]));
        send_request(make_op(OP_QUERY, 32'd0));

        // random phases across idle rates and window settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: write_reg(CfgHeapBytes, 32'hFFFF_FFFF);   // clipped to top
                1: write_reg(CfgHeapBytes, 32'h0000_4000);
                default: write_reg(CfgHeapBytes, $urandom);
            endcase
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 63;
                2: idle_pct = 31;
                default: idle_pct = 63;
            endcase
            for (int n = 0; n < 150; n++) send_request(random_request());
        end

        drain();
        repeat (600) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            if (pending != 0) $error("%0d results never arrived", pending);
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
